// ===== src/bsa_pkg.sv =====
// Shared constants, transaction types and count arithmetic for the safe allocation block.
package bsa_pkg;

   localparam int NUM_PROCS  = 8;
   localparam int COUNT_BITS = 8;
   localparam int NUM_RES    = 3;
   localparam int PROC_BITS  = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;

   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [PROC_BITS-1:0]  proc_idx_type;

   // request codes
   localparam logic [1:0] REQ_SET_AVAIL = 2'd0;
   localparam logic [1:0] REQ_LOAD_ROW  = 2'd1;
   localparam logic [1:0] REQ_REQUEST   = 2'd2;

   // result status codes
   localparam logic [2:0] STATUS_OK         = 3'd0;
   localparam logic [2:0] STATUS_OVER_AVAIL = 3'd1;
   localparam logic [2:0] STATUS_OVER_NEED  = 3'd2;
   localparam logic [2:0] STATUS_UNSAFE     = 3'd3;
   localparam logic [2:0] STATUS_NO_PROC    = 3'd4;

   typedef struct packed {
      logic [1:0] req_type;
      logic [2:0] process;
      logic [7:0] amount_a;
      logic [7:0] amount_b;
      logic [7:0] amount_c;
      logic [7:0] need_a;
      logic [7:0] need_b;
      logic [7:0] need_c;
   } req_item_type;

   typedef struct packed {
      logic [2:0] status;
      logic       retired;
      logic       all_done;
      logic [7:0] avail_a;
      logic [7:0] avail_b;
      logic [7:0] avail_c;
   } rsp_item_type;

   // controls broadcast from the sequencer to every resource lane
   typedef struct packed {
      logic         set_avail;
      logic         load_row;
      logic         start_trial;
      logic         take;
      logic         commit;
      logic         retire;
      logic         use_trial;
      proc_idx_type rd_idx;
      proc_idx_type wr_idx;
   } lane_ctl_type;

   // per-lane findings, merged by the sequencer
   typedef struct packed {
      logic over_avail;
      logic over_need;
      logic fits;
      logic need_zero;
   } lane_stat_type;

   function automatic count_type sat_add(input count_type a, input count_type b);
      logic [COUNT_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[COUNT_BITS] ? {COUNT_BITS{1'b1}} : s[COUNT_BITS-1:0];
   endfunction

endpackage

// ===== src/bsa_lane.sv =====
// One resource lane: available count, held and need columns, work vector entry.
module bsa_lane (
   input  logic                   clock,
   input  logic                   reset,
   input  bsa_pkg::lane_ctl_type  ctl,
   input  bsa_pkg::count_type     amount,
   input  bsa_pkg::count_type     need_val,
   output bsa_pkg::lane_stat_type stat,
   output bsa_pkg::count_type     avail_next
);

   bsa_pkg::count_type avail_ff, avail_in;
   bsa_pkg::count_type work_ff, work_in;
   bsa_pkg::count_type trial_held_ff, trial_held_in;
   bsa_pkg::count_type trial_need_ff, trial_need_in;
   bsa_pkg::count_type held_ff [bsa_pkg::NUM_PROCS];
   bsa_pkg::count_type need_ff [bsa_pkg::NUM_PROCS];

   bsa_pkg::count_type rd_held, rd_need, sel_held, sel_need, granted;

   assign rd_held  = held_ff[ctl.rd_idx];
   assign rd_need  = need_ff[ctl.rd_idx];
   // the requesting row is seen with its trial grant applied
   assign sel_held = ctl.use_trial ? trial_held_ff : rd_held;
   assign sel_need = ctl.use_trial ? trial_need_ff : rd_need;
   assign granted  = avail_ff - amount;

   assign stat.over_avail = amount > avail_ff;
   assign stat.over_need  = amount > rd_need;
   assign stat.fits       = sel_need <= work_ff;
   assign stat.need_zero  = trial_need_ff == '0;

   assign avail_next = avail_in;

   always_comb begin
      avail_in = avail_ff;
      if (ctl.set_avail) begin
         avail_in = amount;
      end else if (ctl.commit) begin
         avail_in = ctl.retire ? bsa_pkg::sat_add(granted, trial_held_ff) : granted;
      end
   end

   always_comb begin
      work_in       = work_ff;
      trial_held_in = trial_held_ff;
      trial_need_in = trial_need_ff;
      if (ctl.start_trial) begin
         work_in       = granted;
         trial_held_in = bsa_pkg::sat_add(rd_held, amount);
         trial_need_in = rd_need - amount;
      end else if (ctl.take) begin
         work_in = bsa_pkg::sat_add(work_ff, sel_held);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         avail_ff <= '0;
      end else begin
         avail_ff <= avail_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff       <= work_in;
      trial_held_ff <= trial_held_in;
      trial_need_ff <= trial_need_in;
      if (ctl.load_row) begin
         held_ff[ctl.wr_idx] <= amount;
         need_ff[ctl.wr_idx] <= need_val;
      end else if (ctl.commit) begin
         held_ff[ctl.wr_idx] <= trial_held_ff;
         need_ff[ctl.wr_idx] <= trial_need_ff;
      end
   end

endmodule

// ===== src/bankers_safe_allocation.sv =====
// Safe resource allocation with a sequential safety scan over three resource lanes.
// One transaction is worked at a time. Set-available, load-row, unused codes and requests
// refused on range, finished process, available or need go from accept through CHECK and
// DONE to the result. A request that reaches the safety check passes CHECK, SCAN, VERDICT
// and DONE; the scan visits one process row per cycle, all three resource lanes compare and
// accumulate side by side, for NUM_PROCS passes. A finished result sits in the output
// register and a new transaction is taken while it waits; the result stage holds only
// when a result is due and the previous one is still stalled.
module bankers_safe_allocation (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  bsa_pkg::req_item_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output bsa_pkg::rsp_item_type rsp_data
);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_CHECK   = 3'd1;
   localparam logic [2:0] ST_SCAN    = 3'd2;
   localparam logic [2:0] ST_VERDICT = 3'd3;
   localparam logic [2:0] ST_DONE    = 3'd4;

   localparam bsa_pkg::proc_idx_type LAST_IDX =
      bsa_pkg::proc_idx_type'(bsa_pkg::NUM_PROCS - 1);

   logic [2:0] state_ff, state_in;
   logic [2:0] status_ff, status_in;
   bsa_pkg::proc_idx_type visit_ff, visit_in, pass_ff, pass_in;
   logic [bsa_pkg::NUM_PROCS-1:0] mark_ff, mark_in, finished_ff, finished_in;
   bsa_pkg::req_item_type item_ff;
   bsa_pkg::rsp_item_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;

   bsa_pkg::lane_ctl_type  ctl;
   bsa_pkg::lane_stat_type lane_stat [bsa_pkg::NUM_RES];
   bsa_pkg::count_type     lane_amount [bsa_pkg::NUM_RES];
   bsa_pkg::count_type     lane_need [bsa_pkg::NUM_RES];
   bsa_pkg::count_type     lane_avail [bsa_pkg::NUM_RES];

   logic [bsa_pkg::NUM_RES-1:0] over_avail_vec, over_need_vec, fits_vec, zero_vec;
   bsa_pkg::proc_idx_type p_idx;
   logic in_range, active, take, out_free, accept;

   assign accept    = req_valid && !req_stall;
   assign req_stall = state_ff != ST_IDLE;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign p_idx    = bsa_pkg::proc_idx_type'(item_ff.process);
   assign in_range = 32'(item_ff.process) < bsa_pkg::NUM_PROCS;

   assign lane_amount[0] = bsa_pkg::count_type'(item_ff.amount_a);
   assign lane_amount[1] = bsa_pkg::count_type'(item_ff.amount_b);
   assign lane_amount[2] = bsa_pkg::count_type'(item_ff.amount_c);
   assign lane_need[0]   = bsa_pkg::count_type'(item_ff.need_a);
   assign lane_need[1]   = bsa_pkg::count_type'(item_ff.need_b);
   assign lane_need[2]   = bsa_pkg::count_type'(item_ff.need_c);

   for (genvar r = 0; r < bsa_pkg::NUM_RES; r++) begin : g_lane
      bsa_lane u_lane (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .amount     (lane_amount[r]),
         .need_val   (lane_need[r]),
         .stat       (lane_stat[r]),
         .avail_next (lane_avail[r])
      );
      assign over_avail_vec[r] = lane_stat[r].over_avail;
      assign over_need_vec[r]  = lane_stat[r].over_need;
      assign fits_vec[r]       = lane_stat[r].fits;
      assign zero_vec[r]       = lane_stat[r].need_zero;
   end

   // merge: a row is taken only when every lane fits
   assign active = !mark_ff[visit_ff] && !finished_ff[visit_ff];
   assign take   = (state_ff == ST_SCAN) && active && (&fits_vec);

   always_comb begin
      state_in    = state_ff;
      status_in   = status_ff;
      visit_in    = visit_ff;
      pass_in     = pass_ff;
      mark_in     = mark_ff;
      finished_in = finished_ff;

      ctl             = '0;
      ctl.take        = take;
      ctl.rd_idx      = (state_ff == ST_SCAN) ? visit_ff : p_idx;
      ctl.wr_idx      = p_idx;
      ctl.use_trial   = (state_ff == ST_SCAN) && (visit_ff == p_idx);

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            status_in = bsa_pkg::STATUS_OK;
            state_in  = ST_DONE;
            if (item_ff.req_type == bsa_pkg::REQ_LOAD_ROW) begin
               if (!in_range) begin
                  status_in = bsa_pkg::STATUS_NO_PROC;
               end
            end else if (item_ff.req_type == bsa_pkg::REQ_REQUEST) begin
               priority if (!in_range || finished_ff[p_idx]) begin
                  status_in = bsa_pkg::STATUS_NO_PROC;
               end else if (|over_avail_vec) begin
                  status_in = bsa_pkg::STATUS_OVER_AVAIL;
               end else if (|over_need_vec) begin
                  status_in = bsa_pkg::STATUS_OVER_NEED;
               end else begin
                  ctl.start_trial = 1'b1;
                  mark_in         = '0;
                  visit_in        = '0;
                  pass_in         = '0;
                  state_in        = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (take) begin
               mark_in[visit_ff] = 1'b1;
            end
            if (visit_ff == LAST_IDX) begin
               visit_in = '0;
               if (pass_ff == LAST_IDX) begin
                  state_in = ST_VERDICT;
               end else begin
                  pass_in = pass_ff + 1'b1;
               end
            end else begin
               visit_in = visit_ff + 1'b1;
            end
         end
         ST_VERDICT: begin
            if (|(~mark_ff & ~finished_ff)) begin
               status_in = bsa_pkg::STATUS_UNSAFE;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // apply all updates in the cycle the result is loaded
            if (out_free) begin
               ctl.set_avail = item_ff.req_type == bsa_pkg::REQ_SET_AVAIL;
               ctl.load_row  = (item_ff.req_type == bsa_pkg::REQ_LOAD_ROW)
                               && (status_ff == bsa_pkg::STATUS_OK);
               ctl.commit    = (item_ff.req_type == bsa_pkg::REQ_REQUEST)
                               && (status_ff == bsa_pkg::STATUS_OK);
               ctl.retire    = ctl.commit && (&zero_vec);
               if (ctl.load_row) begin
                  finished_in[p_idx] = 1'b0;
               end
               if (ctl.retire) begin
                  finished_in[p_idx] = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_in          = rsp_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      if ((state_ff == ST_DONE) && out_free) begin
         rsp_valid_in     = 1'b1;
         rsp_in.status    = status_ff;
         rsp_in.retired   = ctl.retire;
         rsp_in.all_done  = &finished_in;
         rsp_in.avail_a   = 8'(lane_avail[0]);
         rsp_in.avail_b   = 8'(lane_avail[1]);
         rsp_in.avail_c   = 8'(lane_avail[2]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         finished_ff  <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         finished_ff  <= finished_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      visit_ff  <= visit_in;
      pass_ff   <= pass_in;
      mark_ff   <= mark_in;
      rsp_ff    <= rsp_in;
      if (accept) begin
         item_ff <= req_data;
      end
   end

endmodule
